### rtl/double_hash_key_table_core_macros.svh
// Assertion helpers used by the probe sequencer.
`ifndef DOUBLE_HASH_KEY_TABLE_CORE_MACROS_SVH
`define DOUBLE_HASH_KEY_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DHKT_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DHKT_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/dhkt_pkg.sv
`default_nettype none

package dhkt_pkg;

    localparam int KEY_W         = 28;
    localparam int SYMBOLS_W     = 24;
    localparam int LENGTH_W      = 4;
    localparam int STATUS_W      = 2;
    localparam int SLOT_W        = 10;
    localparam int PROBES_W      = 10;
    localparam int SYM_LIMIT     = SYMBOLS_W / 2;
    localparam int GROUP_SIZE    = 4;
    localparam int GROUPS        = SYM_LIMIT / GROUP_SIZE;
    localparam int KEY_RADIX     = 5;
    localparam int RECIP_SHIFT   = KEY_W;
    localparam int QDEPTH        = 8;

    localparam int DEF_TABLE_SIZE  = 1021;
    localparam int DEF_MAX_SYMBOLS = 12;

    localparam logic [STATUS_W-1:0] ST_ABSENT   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    localparam logic MODE_INSERT = 1'b0;

    typedef enum logic [1:0] {
        PS_CLEAR,
        PS_IDLE,
        PS_PROBE,
        PS_DELIVER
    } probe_state_t;

    // Digit (code + 1) weighted by 5^pos.
    function automatic logic [KEY_W-1:0] sym_term(input int pos, input logic [1:0] code);
        logic [KEY_W-1:0] w;
        w = KEY_W'(1);
        for (int k = 0; k < pos; k++)
        begin
            w = KEY_W'(w * KEY_W'(KEY_RADIX));
        end
        return KEY_W'(w * KEY_W'({1'b0, code} + 3'd1));
    endfunction

endpackage

`default_nettype wire

### rtl/dhkt_front.sv
`default_nettype none

module dhkt_front #(
    parameter int TABLE_SIZE  = dhkt_pkg::DEF_TABLE_SIZE,
    parameter int MAX_SYMBOLS = dhkt_pkg::DEF_MAX_SYMBOLS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic                                 mode,
    input  wire logic [dhkt_pkg::SYMBOLS_W-1:0]       symbols,
    input  wire logic [dhkt_pkg::LENGTH_W-1:0]        length,
    output logic                                      job_valid,
    output logic [dhkt_pkg::KEY_W+2*$clog2(TABLE_SIZE):0] job_data
);

    localparam int KEY_W  = dhkt_pkg::KEY_W;
    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int PROD_W = 2 * KEY_W;
    localparam int STAGES = 4;
    localparam logic [KEY_W-1:0] SIZE_A  = KEY_W'(TABLE_SIZE);
    localparam logic [KEY_W-1:0] SIZE_B  = KEY_W'(TABLE_SIZE - 1);
    localparam logic [KEY_W-1:0] RECIP_A =
        KEY_W'((64'd1 << dhkt_pkg::RECIP_SHIFT) / TABLE_SIZE);
    localparam logic [KEY_W-1:0] RECIP_B =
        KEY_W'((64'd1 << dhkt_pkg::RECIP_SHIFT) / (TABLE_SIZE - 1));

    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] mode_reg, mode_next;

    logic [dhkt_pkg::LENGTH_W-1:0] len_sat;
    logic [KEY_W-1:0] psum_reg [dhkt_pkg::GROUPS];
    logic [KEY_W-1:0] psum_next [dhkt_pkg::GROUPS];
    logic [KEY_W-1:0] key2_reg, key2_next;
    logic [KEY_W-1:0] key3_reg, key4_reg;
    logic [KEY_W-1:0] qa_reg, qa_next, qb_reg, qb_next;
    logic [KEY_W-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic [PROD_W-1:0] prod_a, prod_b;
    logic [KEY_W-1:0] ra, rb, ha, hb;

    // Stage 1: weighted digits, summed in groups.
    always_comb
    begin
        len_sat = (length > dhkt_pkg::LENGTH_W'(MAX_SYMBOLS)) ?
                  dhkt_pkg::LENGTH_W'(MAX_SYMBOLS) : length;
        for (int g = 0; g < dhkt_pkg::GROUPS; g++)
        begin
            psum_next[g] = '0;
            for (int k = 0; k < dhkt_pkg::GROUP_SIZE; k++)
            begin
                if (dhkt_pkg::LENGTH_W'(g * dhkt_pkg::GROUP_SIZE + k) < len_sat)
                begin
                    psum_next[g] = psum_next[g] + dhkt_pkg::sym_term(
                        g * dhkt_pkg::GROUP_SIZE + k,
                        symbols[2*(g*dhkt_pkg::GROUP_SIZE+k) +: 2]);
                end
            end
        end
    end

    // Stage 2: full key.
    always_comb
    begin
        key2_next = '0;
        for (int g = 0; g < dhkt_pkg::GROUPS; g++)
        begin
            key2_next = key2_next + psum_reg[g];
        end
    end

    // Stage 3: quotient estimates by reciprocal, low by at most one.
    assign prod_a  = PROD_W'(key2_reg) * PROD_W'(RECIP_A);
    assign prod_b  = PROD_W'(key2_reg) * PROD_W'(RECIP_B);
    assign qa_next = prod_a[dhkt_pkg::RECIP_SHIFT +: KEY_W];
    assign qb_next = prod_b[dhkt_pkg::RECIP_SHIFT +: KEY_W];

    // Stage 4: back-multiply.
    assign pa_next = KEY_W'(qa_reg * SIZE_A);
    assign pb_next = KEY_W'(qb_reg * SIZE_B);

    // Stage 5: remainder with one correction step.
    always_comb
    begin
        ra = key4_reg - pa_reg;
        rb = key4_reg - pb_reg;
        ha = (ra >= SIZE_A) ? ra - SIZE_A : ra;
        hb = (rb >= SIZE_B) ? rb - SIZE_B : rb;
    end

    assign vld_next  = {vld_reg[STAGES-2:0], in_valid};
    assign mode_next = {mode_reg[STAGES-2:0], mode};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        psum_reg <= psum_next;
        key2_reg <= key2_next;
        key3_reg <= key2_reg;
        key4_reg <= key3_reg;
        qa_reg   <= qa_next;
        qb_reg   <= qb_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
    end

    assign job_valid = vld_reg[STAGES-1];
    assign job_data  = {mode_reg[STAGES-1], key4_reg, IDX_W'(ha), IDX_W'(hb + KEY_W'(1))};

endmodule

`default_nettype wire

### rtl/dhkt_queue.sv
`default_nettype none

module dhkt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dhkt_pkg::QDEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_pop;

    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        unique case ({push, do_pop})
            2'b10:   cnt_next = cnt_reg + CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = entry_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);

endmodule

`default_nettype wire

### rtl/dhkt_probe.sv
`default_nettype none

`include "double_hash_key_table_core_macros.svh"

module dhkt_probe #(
    parameter int TABLE_SIZE = dhkt_pkg::DEF_TABLE_SIZE
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     job_valid,
    input  wire logic [dhkt_pkg::KEY_W+2*$clog2(TABLE_SIZE):0] job_data,
    output logic                                          job_pop,
    output logic                                          clearing,
    input  wire logic                                     pop,
    output logic                                          empty,
    output logic [dhkt_pkg::STATUS_W-1:0]                 status,
    output logic [dhkt_pkg::SLOT_W-1:0]                   slot,
    output logic [dhkt_pkg::PROBES_W-1:0]                 probes
);

    localparam int KEY_W   = dhkt_pkg::KEY_W;
    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
    localparam int ENTRY_W = KEY_W + 1;
    localparam int JOB_W   = 1 + KEY_W + 2 * IDX_W;

    dhkt_pkg::probe_state_t state_reg, state_next;

    logic [ENTRY_W-1:0] mem [TABLE_SIZE];
    logic [ENTRY_W-1:0] rd_q_reg;
    logic               rd_en, wr_en;
    logic [IDX_W-1:0]   rd_addr, wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic               job_mode;
    logic [KEY_W-1:0]   job_key;
    logic [IDX_W-1:0]   job_start, job_step;

    logic               mode_reg, mode_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   nxt_reg, nxt_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [dhkt_pkg::STATUS_W-1:0] status_reg, status_next;

    logic               out_valid_reg, out_valid_next;
    logic [dhkt_pkg::STATUS_W-1:0] out_status_reg;
    logic [dhkt_pkg::SLOT_W-1:0]   out_slot_reg;
    logic [dhkt_pkg::PROBES_W-1:0] out_probes_reg;

    logic               start, advance, finish, load_out, out_free;
    logic               hit, vacant, last, done;
    logic [IDX_W-1:0]   sum_base, sum_step;
    logic [IDX_W:0]     sum_raw, sum_wrap;

    assign job_mode  = job_data[JOB_W-1];
    assign job_key   = job_data[JOB_W-2 -: KEY_W];
    assign job_start = job_data[2*IDX_W-1 -: IDX_W];
    assign job_step  = job_data[IDX_W-1:0];

    assign hit      = rd_q_reg[KEY_W] && (rd_q_reg[KEY_W-1:0] == key_reg);
    assign vacant   = !rd_q_reg[KEY_W];
    assign last     = (cnt_reg == CNT_W'(TABLE_SIZE));
    assign done     = hit || vacant || last;
    assign out_free = !out_valid_reg || pop;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dhkt_pkg::PS_CLEAR:
            begin
                if (clr_reg == IDX_W'(TABLE_SIZE - 1))
                begin
                    state_next = dhkt_pkg::PS_IDLE;
                end
            end
            dhkt_pkg::PS_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = dhkt_pkg::PS_PROBE;
                end
            end
            dhkt_pkg::PS_PROBE:
            begin
                if (done)
                begin
                    state_next = dhkt_pkg::PS_DELIVER;
                end
            end
            dhkt_pkg::PS_DELIVER:
            begin
                if (out_free)
                begin
                    state_next = job_valid ? dhkt_pkg::PS_PROBE : dhkt_pkg::PS_IDLE;
                end
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        start    = 1'b0;
        advance  = 1'b0;
        finish   = 1'b0;
        load_out = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = job_start;
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_data  = {1'b1, key_reg};
        clearing = 1'b0;
        unique case (state_reg)
            dhkt_pkg::PS_CLEAR:
            begin
                clearing = 1'b1;
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
            end
            dhkt_pkg::PS_IDLE:
            begin
                start = job_valid;
            end
            dhkt_pkg::PS_PROBE:
            begin
                finish = done;
                wr_en  = vacant && (mode_reg == dhkt_pkg::MODE_INSERT);
                if (!done)
                begin
                    advance = 1'b1;
                    rd_addr = nxt_reg;
                end
            end
            dhkt_pkg::PS_DELIVER:
            begin
                load_out = out_free;
                start    = out_free && job_valid;
            end
        endcase
        rd_en   = start || advance;
        job_pop = start;
    end

    // Next probe slot: modular add of the step
    always_comb
    begin
        sum_base = start ? job_start : nxt_reg;
        sum_step = start ? job_step : step_reg;
        sum_raw  = {1'b0, sum_base} + {1'b0, sum_step};
        sum_wrap = (sum_raw >= (IDX_W+1)'(TABLE_SIZE)) ?
                   sum_raw - (IDX_W+1)'(TABLE_SIZE) : sum_raw;
    end

    always_comb
    begin
        mode_next   = start ? job_mode : mode_reg;
        key_next    = start ? job_key : key_reg;
        step_next   = start ? job_step : step_reg;
        idx_next    = start ? job_start : (advance ? nxt_reg : idx_reg);
        nxt_next    = (start || advance) ? sum_wrap[IDX_W-1:0] : nxt_reg;
        cnt_next    = start ? CNT_W'(1) : (advance ? cnt_reg + CNT_W'(1) : cnt_reg);
        clr_next    = clearing ? clr_reg + IDX_W'(1) : clr_reg;
        status_next = status_reg;
        if (finish)
        begin
            priority if (hit)
            begin
                status_next = dhkt_pkg::ST_PRESENT;
            end
            else if (vacant)
            begin
                status_next = (mode_reg == dhkt_pkg::MODE_INSERT) ?
                              dhkt_pkg::ST_INSERTED : dhkt_pkg::ST_ABSENT;
            end
            else
            begin
                status_next = dhkt_pkg::ST_FULL;
            end
        end
        out_valid_next = load_out ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dhkt_pkg::PS_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        step_reg   <= step_next;
        idx_reg    <= idx_next;
        nxt_reg    <= nxt_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_slot_reg   <= dhkt_pkg::SLOT_W'(idx_reg);
            out_probes_reg <= dhkt_pkg::PROBES_W'(cnt_reg);
        end
    end

    // Slot table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    assign empty  = !out_valid_reg;
    assign status = out_status_reg;
    assign slot   = out_slot_reg;
    assign probes = out_probes_reg;

    `DHKT_ASSERT_NOW(a_write_on_vacant_insert, wr_en && (state_reg == dhkt_pkg::PS_PROBE), (mode_reg == dhkt_pkg::MODE_INSERT) && !rd_q_reg[KEY_W], "table write outside an insert into a vacant slot")
    `DHKT_ASSERT_NOW(a_pop_needs_job, job_pop, job_valid && !clearing, "job taken from an empty queue")
    `DHKT_ASSERT_NOW(a_count_bound, state_reg == dhkt_pkg::PS_PROBE, (cnt_reg != '0) && (cnt_reg <= CNT_W'(TABLE_SIZE)), "probe count out of range")
    `DHKT_ASSERT_NEXT(a_deliver_loads, (state_reg == dhkt_pkg::PS_DELIVER) && out_free, !empty, "finished item not presented")

endmodule

`default_nettype wire

### rtl/double_hash_key_table_core.sv
// Double-hashing key table: insert or find nucleotide strings of up to 12 symbols.
// Input channel: push/full. An item (mode, symbols, length) is taken on a clock
// edge with push high and full low. Result channel: empty/pop. While empty is
// low, status/slot/probes show the oldest result; pop takes it.
// Front end: a 4-stage pipeline turns the string into its base-5 key and both
// hashes (key mod TABLE_SIZE, 1 + key mod (TABLE_SIZE-1)); it takes one item
// per cycle while full is low and feeds an 8-entry job queue. full rises when
// front end and queue together hold 8 items.
// Back end: a probe sequencer with a single-port-read slot table. It issues the
// first read, examines one slot per read, and hands the result to the output
// register, the last step overlapping the next item's first read; it works on
// one item at a time.
// After reset the table is swept clear, one slot a cycle, with full held high.
// When the receiver stalls, the result waits in the output register, the
// sequencer waits behind it, and the queue absorbs new items until full rises.
`default_nettype none

module double_hash_key_table_core #(
    parameter int TABLE_SIZE  = dhkt_pkg::DEF_TABLE_SIZE,
    parameter int MAX_SYMBOLS = dhkt_pkg::DEF_MAX_SYMBOLS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          mode,
    input  wire logic [dhkt_pkg::SYMBOLS_W-1:0] symbols,
    input  wire logic [dhkt_pkg::LENGTH_W-1:0]  length,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [dhkt_pkg::STATUS_W-1:0]      status,
    output logic [dhkt_pkg::SLOT_W-1:0]        slot,
    output logic [dhkt_pkg::PROBES_W-1:0]      probes
);

    localparam int JOB_W = 1 + dhkt_pkg::KEY_W + 2 * $clog2(TABLE_SIZE);
    localparam int CR_W  = $clog2(dhkt_pkg::QDEPTH + 1);

    logic             accept;
    logic             front_valid;
    logic [JOB_W-1:0] front_data;
    logic [JOB_W-1:0] job_data;
    logic             job_empty;
    logic             job_pop;
    logic             clearing;
    logic [CR_W-1:0]  credit_reg, credit_next;

    // Count items between the input and the sequencer so the queue never overflows
    assign accept = push && !full;
    assign full   = clearing || (credit_reg == CR_W'(dhkt_pkg::QDEPTH));

    always_comb
    begin
        unique case ({accept, job_pop})
            2'b10:   credit_next = credit_reg + CR_W'(1);
            2'b01:   credit_next = credit_reg - CR_W'(1);
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    dhkt_front #(
        .TABLE_SIZE  (TABLE_SIZE),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .mode      (mode),
        .symbols   (symbols),
        .length    (length),
        .job_valid (front_valid),
        .job_data  (front_data)
    );

    dhkt_queue #(
        .WIDTH (JOB_W),
        .DEPTH (dhkt_pkg::QDEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .wdata (front_data),
        .pop   (job_pop),
        .rdata (job_data),
        .empty (job_empty)
    );

    dhkt_probe #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_probe (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!job_empty),
        .job_data  (job_data),
        .job_pop   (job_pop),
        .clearing  (clearing),
        .pop       (pop),
        .empty     (empty),
        .status    (status),
        .slot      (slot),
        .probes    (probes)
    );

endmodule

`default_nettype wire

### tb/sv/double_hash_key_table_checker.sv
`default_nettype none

module double_hash_key_table_checker #(
    parameter int TABLE_SIZE  = dhkt_pkg::DEF_TABLE_SIZE,
    parameter int MAX_SYMBOLS = dhkt_pkg::DEF_MAX_SYMBOLS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire logic                           full,
    input  wire logic                           mode,
    input  wire logic [dhkt_pkg::SYMBOLS_W-1:0] symbols,
    input  wire logic [dhkt_pkg::LENGTH_W-1:0]  length,
    input  wire logic                           empty,
    input  wire logic                           pop,
    input  wire logic [dhkt_pkg::STATUS_W-1:0]  status,
    input  wire logic [dhkt_pkg::SLOT_W-1:0]    slot,
    input  wire logic [dhkt_pkg::PROBES_W-1:0]  probes,
    output int                                  mismatches,
    output int                                  outstanding
);

    localparam int KW = dhkt_pkg::KEY_W;

    typedef struct packed {
        logic [dhkt_pkg::STATUS_W-1:0] status;
        logic [dhkt_pkg::SLOT_W-1:0]   slot;
        logic [dhkt_pkg::PROBES_W-1:0] probes;
    } lookup_outcome_t;

    // Bit KW is the occupied flag, the rest holds the key.
    logic [KW:0]     key_slots [0:TABLE_SIZE-1];
    lookup_outcome_t awaited_outcomes [$];

    function automatic lookup_outcome_t probe_and_record(
        input logic                           req_mode,
        input logic [dhkt_pkg::SYMBOLS_W-1:0] req_syms,
        input logic [dhkt_pkg::LENGTH_W-1:0]  req_len
    );
        int unsigned     n_sym;
        int unsigned     key;
        int unsigned     weight;
        int unsigned     idx;
        int unsigned     stride;
        int unsigned     count;
        int              i;
        bit              done;
        lookup_outcome_t res;
        n_sym  = (req_len > MAX_SYMBOLS) ? MAX_SYMBOLS : req_len;
        key    = 0;
        weight = 1;
        for (i = 0; i < n_sym; i++)
        begin
            key    = key + (req_syms[2*i +: 2] + 1) * weight;
            weight = weight * dhkt_pkg::KEY_RADIX;
        end
        key        = key & ((32'd1 << KW) - 1);
        idx        = key % TABLE_SIZE;
        stride     = 1 + key % (TABLE_SIZE - 1);
        count      = 0;
        done       = 1'b0;
        res.status = dhkt_pkg::ST_FULL;
        while (!done)
        begin
            count++;
            if (key_slots[idx][KW] && key_slots[idx][KW-1:0] == key[KW-1:0])
            begin
                res.status = dhkt_pkg::ST_PRESENT;
                done       = 1'b1;
            end
            else if (!key_slots[idx][KW])
            begin
                if (req_mode == dhkt_pkg::MODE_INSERT)
                begin
                    key_slots[idx] = {1'b1, key[KW-1:0]};
                    res.status     = dhkt_pkg::ST_INSERTED;
                end
                else
                begin
                    res.status = dhkt_pkg::ST_ABSENT;
                end
                done = 1'b1;
            end
            else if (count >= TABLE_SIZE)
            begin
                // every slot taken by other keys: nothing is written
                res.status = dhkt_pkg::ST_FULL;
                done       = 1'b1;
            end
            else
            begin
                idx = idx + stride;
                if (idx >= TABLE_SIZE)
                begin
                    idx = idx - TABLE_SIZE;
                end
            end
        end
        res.slot   = idx[dhkt_pkg::SLOT_W-1:0];
        res.probes = count[dhkt_pkg::PROBES_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_outcome_t want;
        lookup_outcome_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                key_slots[i] = '0;
            end
            awaited_outcomes.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Check the result first: it always belongs to an older item.
            if (pop && !empty)
            begin
                got = '{status: status, slot: slot, probes: probes};
                if (awaited_outcomes.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected result: status %0d slot %0d probes %0d",
                                 got.status, got.slot, got.probes);
                    end
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("mismatch: expected status %0d slot %0d probes %0d, got status %0d slot %0d probes %0d",
                                     want.status, want.slot, want.probes,
                                     got.status, got.slot, got.probes);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (push && !full)
            begin
                awaited_outcomes.push_back(probe_and_record(mode, symbols, length));
            end
            outstanding <= awaited_outcomes.size();
        end
    end

endmodule

`default_nettype wire

### tb/sv/tb_double_hash_key_table_core.sv
`default_nettype none

module tb_double_hash_key_table_core;

    localparam logic MODE_FIND        = ~dhkt_pkg::MODE_INSERT;
    localparam int   TABLE_SIZE       = dhkt_pkg::DEF_TABLE_SIZE;
    localparam int   STALL_LIMIT      = 8000;
    localparam int   END_WAIT         = 64;
    localparam int   ITEMS_PER_PHASE  = 300;
    localparam int   FILL_SLACK       = 40;

    logic                           clk     = 1'b0;
    logic                           rst_n   = 1'b0;
    logic                           push    = 1'b0;
    logic                           mode    = 1'b0;
    logic [dhkt_pkg::SYMBOLS_W-1:0] symbols = '0;
    logic [dhkt_pkg::LENGTH_W-1:0]  length  = '0;
    logic                           pop     = 1'b0;
    logic                           full;
    logic                           empty;
    logic [dhkt_pkg::STATUS_W-1:0]  status;
    logic [dhkt_pkg::SLOT_W-1:0]    slot;
    logic [dhkt_pkg::PROBES_W-1:0]  probes;

    int mismatches;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int unsigned fresh_cnt = 0;

    double_hash_key_table_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .mode    (mode),
        .symbols (symbols),
        .length  (length),
        .empty   (empty),
        .pop     (pop),
        .status  (status),
        .slot    (slot),
        .probes  (probes)
    );

    double_hash_key_table_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .symbols     (symbols),
        .length      (length),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .slot        (slot),
        .probes      (probes),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_double_hash_key_table_core: done, errors");
                $finish;
            end
        end
    end

    // Distinct full-length strings: odd multiplier and xor are both bijective.
    function automatic logic [dhkt_pkg::SYMBOLS_W-1:0] fresh_symbols(input int unsigned n);
        return dhkt_pkg::SYMBOLS_W'(n * 32'h009E3779) ^ 24'h5A5A5A;
    endfunction

    task automatic send_item(
        input logic                           req_mode,
        input logic [dhkt_pkg::SYMBOLS_W-1:0] req_syms,
        input logic [dhkt_pkg::LENGTH_W-1:0]  req_len
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        mode    <= req_mode;
        symbols <= req_syms;
        length  <= req_len;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic random_item();
        int unsigned pick;
        int unsigned known;
        pick  = $urandom_range(99);
        known = (fresh_cnt == 0) ? 0 : $urandom_range(fresh_cnt - 1);
        if (pick < 35 || fresh_cnt == 0)
        begin
            send_item(dhkt_pkg::MODE_INSERT, fresh_symbols(fresh_cnt), 4'd12);
            fresh_cnt++;
        end
        else if (pick < 55)
        begin
            send_item(MODE_FIND, fresh_symbols(known), 4'd12);
        end
        else if (pick < 65)
        begin
            send_item(dhkt_pkg::MODE_INSERT, fresh_symbols(known), 4'd12);
        end
        else if (pick < 80)
        begin
            send_item(MODE_FIND, dhkt_pkg::SYMBOLS_W'($urandom),
                      dhkt_pkg::LENGTH_W'($urandom_range(15)));
        end
        else
        begin
            send_item(dhkt_pkg::MODE_INSERT, dhkt_pkg::SYMBOLS_W'($urandom),
                      dhkt_pkg::LENGTH_W'($urandom_range(15)));
        end
    endtask

    initial
    begin
        int fill_cnt;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // first lookup on an empty table, then insert and hit
        send_item(MODE_FIND,             24'h000000, 4'd12);
        send_item(dhkt_pkg::MODE_INSERT, 24'h000000, 4'd12);
        send_item(dhkt_pkg::MODE_INSERT, 24'h000000, 4'd12);
        send_item(MODE_FIND,             24'h000000, 4'd12);
        // largest key
        send_item(dhkt_pkg::MODE_INSERT, 24'hFFFFFF, 4'd12);
        send_item(MODE_FIND,             24'hFFFFFF, 4'd12);
        // empty string maps to key 0 whatever the symbols
        send_item(MODE_FIND,             24'h123456, 4'd0);
        send_item(dhkt_pkg::MODE_INSERT, 24'hA5A5A5, 4'd0);
        send_item(MODE_FIND,             24'h5A5A5A, 4'd0);
        // symbols past the length are ignored
        send_item(dhkt_pkg::MODE_INSERT, 24'h000000, 4'd1);
        send_item(dhkt_pkg::MODE_INSERT, 24'hFFFFFF, 4'd1);
        send_item(MODE_FIND,             24'h000003, 4'd1);
        send_item(MODE_FIND,             24'hFFFFFC, 4'd1);
        // lengths above the limit saturate
        send_item(dhkt_pkg::MODE_INSERT, 24'h9C3E71, 4'd15);
        send_item(MODE_FIND,             24'h9C3E71, 4'd12);
        send_item(dhkt_pkg::MODE_INSERT, 24'h9C3E71, 4'd13);
        send_item(MODE_FIND,             24'h9C3E71, 4'd14);
        send_item(MODE_FIND,             24'h9C3E71, 4'd11);
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            repeat (ITEMS_PER_PHASE) random_item();
            // hold off until every result is back
            drain_results();
        end

        // Fill the table past its capacity so that probes wrap all the way.
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        fill_cnt = TABLE_SIZE - int'(fresh_cnt) + FILL_SLACK;
        repeat (fill_cnt)
        begin
            send_item(dhkt_pkg::MODE_INSERT, fresh_symbols(fresh_cnt), 4'd12);
            fresh_cnt++;
        end
        for (int j = 0; j < 20; j++)
        begin
            send_item(MODE_FIND, fresh_symbols(fresh_cnt + j), 4'd12);
        end
        repeat (10) send_item(MODE_FIND, fresh_symbols($urandom_range(fresh_cnt - 1)), 4'd12);
        repeat (10) send_item(dhkt_pkg::MODE_INSERT, dhkt_pkg::SYMBOLS_W'($urandom),
                              dhkt_pkg::LENGTH_W'($urandom_range(15)));
        drain_results();

        repeat (END_WAIT) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("tb_double_hash_key_table_core: done, clean");
        end
        else
        begin
            $display("tb_double_hash_key_table_core: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
